// ===== src/grm_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the grid ray
// marcher. No dependencies.
`timescale 1ns / 1ps

package grm_pkg;

	localparam int GRID_DIM_DEF    = 8;
	localparam int TILE_PIXELS_DEF = 60;
	localparam int RAY_COUNT_DEF   = 160;

	localparam int DIV_NUM_W = 32;
	localparam int DIV_DEN_W = 24;

	localparam logic [15:0] RAY_FAN_START = 16'd5461;
	localparam logic [15:0] QUARTER_TURN  = 16'd16384;
	localparam logic [31:0] HEIGHT_NUM    = 32'd344064000; // 21000 in Q14
	localparam logic [8:0]  HEIGHT_MAX    = 9'd480;
	localparam logic [31:0] SHADE_NUM     = 32'd2550000;
	localparam logic [23:0] SHADE_BIAS    = 24'd10000;
	localparam logic [13:0] COL_BASE      = 14'd480;
	localparam logic [13:0] COL_MAX       = 14'd1023;
	localparam int          COL_SPAN      = 480;
	localparam logic [8:0]  STRIP_MID     = 9'd240;

	localparam logic [14:0] QSIN [0:64] = '{
		15'd0, 15'd402, 15'd804, 15'd1205, 15'd1606, 15'd2006, 15'd2404, 15'd2801,
		15'd3196, 15'd3590, 15'd3981, 15'd4370, 15'd4756, 15'd5139, 15'd5520, 15'd5897,
		15'd6270, 15'd6639, 15'd7005, 15'd7366, 15'd7723, 15'd8076, 15'd8423, 15'd8765,
		15'd9102, 15'd9434, 15'd9760, 15'd10080, 15'd10394, 15'd10702, 15'd11003, 15'd11297,
		15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916, 15'd13160,
		15'd13395, 15'd13623, 15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635,
		15'd14811, 15'd14978, 15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679,
		15'd15791, 15'd15893, 15'd15986, 15'd16069, 15'd16143, 15'd16207, 15'd16261,
		15'd16305, 15'd16340, 15'd16364, 15'd16379, 15'd16384
	};

	typedef struct packed {
		logic [7:0]  ray_index;
		logic [15:0] viewer_x;
		logic [15:0] viewer_y;
		logic [15:0] viewer_heading;
	} ray_req_t;

	typedef struct packed {
		logic [9:0] screen_column;
		logic [7:0] strip_top;
		logic [8:0] strip_height;
		logic [7:0] shade;
		logic [7:0] ray_echo;
	} ray_res_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== src/grm_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on grm_pkg for the request and response structs.
`timescale 1ns / 1ps

module grm_div import grm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DIV_DEN_W-1:0];
			end
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ===== src/grm_sincos.sv =====
// Q1.14 sine of a 16-bit binary angle: quarter-wave table plus linear
// interpolation. Depends on grm_pkg for the table.
`timescale 1ns / 1ps

module grm_sincos import grm_pkg::*; (
	input  logic [15:0]        angle,
	output logic signed [15:0] sine
);

	logic [14:0] pos;
	logic [6:0]  idx;
	logic [7:0]  frac;
	logic [14:0] base;
	logic [14:0] nxt;
	logic [8:0]  diff;
	logic [16:0] step;
	logic [14:0] mag;

	always_comb begin
		// mirror odd quadrants
		pos  = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
		idx  = pos[14:8];
		frac = pos[7:0];
		base = QSIN[idx];
		nxt  = (idx >= 7'd64) ? QSIN[64] : QSIN[7'(idx + 7'd1)];
		diff = 9'(nxt - base);
		step = 17'(diff * frac) + 17'd128;
		mag  = (idx >= 7'd64) ? QSIN[64] : 15'(base + {6'b0, step[16:8]});
		sine = angle[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

// ===== src/grid_ray_march_column.sv =====
// Sequence per ray: the ray offset (S_OFS), three sine/cosine lookups (S_SIN, S_COS, S_FC),
// one march step per cycle to the hit, then two passes through the shared divider, one for
// height and one for shade; a ray with no forward component skips the height pass.
// A ray with no hit gives no word and frees the input once the march limit is reached.
// One ray at a time: req_stall is high from accept until the cycle after the result.
// Reset clears the sequencer and the wall bitmap to all open tiles.
`timescale 1ns / 1ps

module grid_ray_march_column import grm_pkg::*; #(
	parameter int GRID_DIM    = GRID_DIM_DEF,
	parameter int TILE_PIXELS = TILE_PIXELS_DEF,
	parameter int RAY_COUNT   = RAY_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        bitmap_we,
	input  logic [63:0] bitmap_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  ray_req_t    req,
	output logic        res_valid,
	input  logic        res_stall,
	output ray_res_t    res
);

	localparam int MARCH_LIMIT = GRID_DIM * TILE_PIXELS;
	localparam int DW          = $clog2(MARCH_LIMIT);
	localparam int CW          = 26;
	localparam int CNT_W       = $clog2(GRID_DIM + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_OFS   = 9'b000000010,
		S_SIN   = 9'b000000100,
		S_COS   = 9'b000001000,
		S_FC    = 9'b000010000,
		S_MARCH = 9'b000100000,
		S_HDIV  = 9'b001000000,
		S_SDIV  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t               state_q;
	logic [63:0]          bitmap_q;
	ray_req_t             in_q;
	ray_res_t             res_q;
	logic [15:0]          ofs_q;
	logic signed [15:0]   s_q;
	logic signed [15:0]   c_q;
	logic signed [15:0]   fc_q;
	logic signed [CW-1:0] tx_q;
	logic signed [CW-1:0] ty_q;
	logic [DW-1:0]        depth_q;
	logic                 div_start_q;
	logic [DIV_NUM_W-1:0] div_num_q;
	logic [DIV_DEN_W-1:0] div_den_q;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	logic [15:0]          trig_angle;
	logic signed [15:0]   trig_val;
	logic [CNT_W-1:0]     col_cnt;
	logic [CNT_W-1:0]     row_cnt;
	logic                 wall;
	logic signed [CW-1:0] s_ext;
	logic signed [CW-1:0] c_ext;
	logic [15:0]          ofs_tab [256];
	logic [9:0]           col_tab [256];

	// per-ray angle step and screen column, fixed by the parameters
	for (genvar g = 0; g < 256; g++) begin : g_ray_tab
		localparam int COL = int'(COL_BASE) + g * COL_SPAN / RAY_COUNT;
		assign ofs_tab[g] = 16'(g * 65536 / (6 * RAY_COUNT));
		assign col_tab[g] = (COL > int'(COL_MAX)) ? 10'(COL_MAX) : 10'(COL);
	end

	assign div_req = '{start: div_start_q, num: div_num_q, den: div_den_q};

	grm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	grm_sincos u_trig (
		.angle (trig_angle),
		.sine  (trig_val)
	);

	always_comb begin
		unique case (state_q)
			S_SIN:   trig_angle = 16'(in_q.viewer_heading + ofs_q);
			S_COS:   trig_angle = 16'(in_q.viewer_heading + ofs_q + QUARTER_TURN);
			default: trig_angle = 16'(ofs_q + QUARTER_TURN);
		endcase
	end

	assign s_ext = {{(CW-16){s_q[15]}}, s_q};
	assign c_ext = {{(CW-16){c_q[15]}}, c_q};

	// tile index along each axis by compare against every tile boundary
	always_comb begin
		col_cnt = '0;
		row_cnt = '0;
		for (int k = 1; k <= GRID_DIM; k++) begin
			if (tx_q >= $signed(CW'(k * TILE_PIXELS * 16384)))
				col_cnt = col_cnt + 1'b1;
			if (ty_q >= $signed(CW'(k * TILE_PIXELS * 16384)))
				row_cnt = row_cnt + 1'b1;
		end
		wall = tx_q[CW-1] || ty_q[CW-1]
			|| (col_cnt >= CNT_W'(GRID_DIM)) || (row_cnt >= CNT_W'(GRID_DIM))
			|| bitmap_q[6'(row_cnt * GRID_DIM + col_cnt)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q <= '0;
		end else if (bitmap_we) begin
			bitmap_q <= bitmap_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= ((state_q == S_MARCH) && wall)
				|| ((state_q == S_HDIV) && div_rsp.done);
			unique case (state_q)
				S_IDLE: begin
					if (req_valid)
						state_q <= S_OFS;
				end
				S_OFS:   state_q <= S_SIN;
				S_SIN:   state_q <= S_COS;
				S_COS:   state_q <= S_FC;
				S_FC:    state_q <= S_MARCH;
				S_MARCH: begin
					if (wall) begin
						state_q <= (fc_q > 16'sd0) ? S_HDIV : S_SDIV;
					end else if (depth_q == DW'(MARCH_LIMIT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_HDIV: begin
					if (div_rsp.done)
						state_q <= S_SDIV;
				end
				S_SDIV: begin
					if (div_rsp.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: in_q <= req;
			S_OFS: begin
				ofs_q <= ofs_tab[in_q.ray_index] - RAY_FAN_START;
			end
			S_SIN: s_q <= trig_val;
			S_COS: c_q <= trig_val;
			S_FC: begin
				fc_q    <= trig_val;
				tx_q    <= $signed({3'b0, in_q.viewer_x, 7'b0}) - s_ext;
				ty_q    <= $signed({3'b0, in_q.viewer_y, 7'b0}) + c_ext;
				depth_q <= DW'(1);
			end
			S_MARCH: begin
				if (wall) begin
					res_q.ray_echo <= in_q.ray_index;
					if (fc_q > 16'sd0) begin
						div_num_q <= HEIGHT_NUM;
						div_den_q <= DIV_DEN_W'(depth_q * fc_q[14:0]);
					end else begin
						// no forward component: full-height strip
						res_q.strip_height <= HEIGHT_MAX;
						res_q.strip_top    <= 8'(STRIP_MID - {1'b0, HEIGHT_MAX[8:1]});
						div_num_q          <= SHADE_NUM;
						div_den_q          <= DIV_DEN_W'(depth_q * depth_q) + SHADE_BIAS;
					end
				end else begin
					depth_q <= depth_q + 1'b1;
					tx_q    <= tx_q - s_ext;
					ty_q    <= ty_q + c_ext;
				end
			end
			S_HDIV: begin
				if (div_rsp.done) begin
					if (div_rsp.quot > DIV_NUM_W'(HEIGHT_MAX)) begin
						res_q.strip_height <= HEIGHT_MAX;
						res_q.strip_top    <= 8'(STRIP_MID - {1'b0, HEIGHT_MAX[8:1]});
					end else begin
						res_q.strip_height <= div_rsp.quot[8:0];
						res_q.strip_top    <= 8'(STRIP_MID - {1'b0, div_rsp.quot[8:1]});
					end
					div_num_q <= SHADE_NUM;
					div_den_q <= DIV_DEN_W'(depth_q * depth_q) + SHADE_BIAS;
				end
			end
			S_SDIV: begin
				if (div_rsp.done) begin
					res_q.shade         <= div_rsp.quot[7:0];
					res_q.screen_column <= col_tab[in_q.ray_index];
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign res       = res_q;

endmodule

// ===== tb/grid_ray_march_column_test.sv =====
// Self-checking testbench for grid_ray_march_column: casts rays from directed and
// random viewer poses over several wall bitmaps. Depends on grm_pkg and the block.
`timescale 1ns / 1ps

module grid_ray_march_column_test;
	import grm_pkg::*;

	localparam int GRID  = 8;
	localparam int TILE  = 60;
	localparam int RAYS  = 160;
	localparam int DEPTH_LIMIT = GRID * TILE;
	localparam int IDLE_LIMIT  = 20000;
	localparam int SETTLE      = 700;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        bitmap_we = 1'b0;
	logic [63:0] bitmap_data = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	ray_req_t    req = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	ray_res_t    res;

	logic [63:0] walls = '0;
	ray_res_t    strip_queue[$];
	int          fail_count = 0;
	int          rays_cast = 0;
	int          strips_seen = 0;
	int          idle_cycles = 0;
	bit          stim_done = 1'b0;

	grid_ray_march_column dut (
		.clk(clk), .arst_n(arst_n),
		.bitmap_we(bitmap_we), .bitmap_data(bitmap_data),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int quarter_sin(int pos);
		int i;
		int f;
		int b;
		i = pos >>> 8;
		f = pos & 255;
		if (i >= 64) return int'(QSIN[64]);
		b = int'(QSIN[i]);
		return b + ((((int'(QSIN[i + 1]) - b) * f) + 128) >>> 8);
	endfunction

	function automatic int sine_q14(logic [15:0] a);
		int p;
		int v;
		p = a[13:0];
		v = a[14] ? quarter_sin(16384 - p) : quarter_sin(p);
		return a[15] ? -v : v;
	endfunction

	function automatic int tile_idx(longint c);
		longint t;
		if (c < 0) return -1;
		t = c / (TILE * 16384);
		return (t >= GRID) ? -1 : int'(t);
	endfunction

	// March one ray; returns 1 and the strip on a wall hit
	function automatic bit cast_ray(ray_req_t r, output ray_res_t s);
		logic [15:0] offset;
		logic [15:0] angle;
		int sn, cs, fc, col, row;
		longint tx, ty, h, column;
		s = '0;
		offset = 16'((int'(r.ray_index) * 65536 / (6 * RAYS)) - 5461);
		angle = r.viewer_heading + offset;
		sn = sine_q14(angle);
		cs = sine_q14(angle + 16'd16384);
		for (int d = 1; d < DEPTH_LIMIT; d++) begin
			tx = (longint'(r.viewer_x) << 7) - longint'(sn) * d;
			ty = (longint'(r.viewer_y) << 7) + longint'(cs) * d;
			col = tile_idx(tx);
			row = tile_idx(ty);
			if (col < 0 || row < 0 || walls[row * GRID + col]) begin
				fc = sine_q14(offset + 16'd16384);
				if (fc <= 0) h = 480;
				else h = 64'd344064000 / (longint'(d) * fc);
				if (h > 480) h = 480;
				column = 480 + int'(r.ray_index) * 480 / RAYS;
				if (column > 1023) column = 1023;
				s.screen_column = 10'(column);
				s.strip_height = 9'(h);
				s.strip_top = 8'(240 - (h >> 1));
				s.shade = 8'(2550000 / (10000 + d * d));
				s.ray_echo = r.ray_index;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Check each strip against the oldest prediction
	always @(posedge clk) begin
		ray_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			strips_seen++;
			if (strip_queue.size() == 0) begin
				$display("%0t: unexpected strip %p", $time, res);
				fail_count++;
			end else begin
				want = strip_queue.pop_front();
				if (res.screen_column !== want.screen_column) begin
					$display("%0t: column exp %0d got %0d", $time, want.screen_column,
						res.screen_column);
					fail_count++;
				end
				if (res.strip_top !== want.strip_top) begin
					$display("%0t: top exp %0d got %0d", $time, want.strip_top, res.strip_top);
					fail_count++;
				end
				if (res.strip_height !== want.strip_height) begin
					$display("%0t: height exp %0d got %0d", $time, want.strip_height,
						res.strip_height);
					fail_count++;
				end
				if (res.shade !== want.shade) begin
					$display("%0t: shade exp %0d got %0d", $time, want.shade, res.shade);
					fail_count++;
				end
				if (res.ray_echo !== want.ray_echo) begin
					$display("%0t: echo exp %0d got %0d", $time, want.ray_echo, res.ray_echo);
					fail_count++;
				end
			end
		end
	end

	// Receiver stall pattern: quiet stretches, then random stalls
	always @(posedge clk) begin
		int phase;
		phase = int'(($time / 8) % 3000);
		res_stall <= (phase < 800) ? 1'b0 : ($urandom_range(0, 2) == 0);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("Verification failed");
			$finish;
		end
	end

	// Leave valid up after the accept; drop it only before a wait
	task automatic send_ray(ray_req_t r);
		ray_res_t s;
		if (cast_ray(r, s)) strip_queue.push_back(s);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		rays_cast++;
	endtask

	task automatic hold_off();
		req_valid <= 1'b0;
	endtask

	task automatic drain_and_idle();
		hold_off();
		while (strip_queue.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_walls(logic [63:0] v);
		drain_and_idle();
		walls = v;
		bitmap_data <= v;
		bitmap_we <= 1'b1;
		@(posedge clk);
		bitmap_we <= 1'b0;
	endtask

	function automatic ray_req_t any_ray();
		ray_req_t r;
		r.ray_index = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, RAYS - 1));
		r.viewer_x = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 61439));
		r.viewer_y = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 61439));
		r.viewer_heading = 16'($urandom);
		return r;
	endfunction

	task automatic test_directed();
		ray_req_t r;
		// Open map: only the border stops the ray
		load_walls(64'h0);
		send_ray('{8'd0, 16'd30720, 16'd30720, 16'd0});
		send_ray('{8'd159, 16'd30720, 16'd30720, 16'd16384});
		send_ray('{8'd80, 16'd0, 16'd0, 16'd32768});
		send_ray('{8'd80, 16'd61439, 16'd61439, 16'd49152});
		send_ray('{8'd255, 16'd30720, 16'd30720, 16'd65535});
		send_ray('{8'd200, 16'hFFFF, 16'hFFFF, 16'd0});
		send_ray('{8'd40, 16'd128, 16'd30720, 16'd16384});
		// Full map: hit at depth one, height saturates
		load_walls({64{1'b1}});
		send_ray('{8'd0, 16'd0, 16'd0, 16'd0});
		send_ray('{8'd159, 16'd61439, 16'd61439, 16'hFFFF});
		send_ray('{8'd170, 16'd7680, 16'd7680, 16'd8192});
		// Perimeter walls with a center room
		load_walls(64'hFF81_8181_8181_81FF);
		for (int i = 0; i < 8; i++) begin
			r = '{8'(i * 22), 16'd30720, 16'd30720, 16'(i * 8192)};
			send_ray(r);
		end
	endtask

	task automatic test_random(int count);
		int burst;
		for (int n = 0; n < count; ) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && n < count; b++, n++) send_ray(any_ray());
			if ($urandom_range(0, 3) != 0) begin
				hold_off();
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	endtask

	task automatic test_bitmaps();
		load_walls(64'h5555_AAAA_5555_AAAA);
		test_random(300);
		load_walls({32'($urandom), 32'($urandom)});
		test_random(300);
		load_walls(64'h8000_0000_0000_0001);
		test_random(300);
		load_walls({32'($urandom), 32'($urandom)} & {32'($urandom), 32'($urandom)});
		test_random(330);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_bitmaps();
		drain_and_idle();
		$display("Cast %0d rays over several wall maps, %0d strips checked.", rays_cast,
			strips_seen);
		if (fail_count == 0 && strip_queue.size() == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
